/* rtl/ted_pkg.sv */
`default_nettype none

package ted_pkg;

   // encoding codes, shared by the register, the scanner and the result
   localparam logic [1:0] ENC_ANSI    = 2'd0;
   localparam logic [1:0] ENC_UTF8    = 2'd1;
   localparam logic [1:0] ENC_UTF16LE = 2'd2;
   localparam logic [1:0] ENC_DETECT  = 2'd3;

   // UTF-8 byte classes
   localparam logic [7:0] BYTE_HIGH  = 8'h80;
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] LEAD_BAD   = 8'hF8;
   localparam logic [1:0] CONT_TAG   = 2'b10;

   // one window entry: only whether the byte was NUL matters downstream
   typedef struct packed {
      logic valid;
      logic zero;
   } tap_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/ted_req_if.sv */
`default_nettype none

interface ted_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

/* rtl/ted_rsp_if.sv */
`default_nettype none

interface ted_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] encoding;

   modport source (output valid, output encoding, input ready);
   modport sink   (input valid, input encoding, output ready);
endinterface

`default_nettype wire

/* rtl/ted_cell.sv */
`default_nettype none

module ted_cell
   import ted_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire tap_type       din,
   output tap_type            dout
);

   logic valid_ff, valid_in;
   logic zero_ff, zero_in;

   // clear wins over shift
   always_comb begin
      valid_in = valid_ff;
      zero_in  = zero_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in = din.valid;
         zero_in  = din.zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
   end

   assign dout = '{valid: valid_ff, zero: zero_ff};

endmodule

`default_nettype wire

/* rtl/ted_scan.sv */
`default_nettype none

module ted_scan
   import ted_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] text_byte,
   input  wire logic       final_byte,
   input  wire tap_type    head,
   input  wire logic       odd_any,
   input  wire logic       even_any,
   output cell_ctrl_type    head_ctrl,
   output cell_ctrl_type    body_ctrl,
   output tap_type          head_tap,
   output logic [1:0]       detect
);

   localparam logic PHASE_UTF8 = 1'b0;
   localparam logic PHASE_WIDE = 1'b1;

   logic       phase_ff, phase_in;
   logic [1:0] cont_ff, cont_in;
   logic       multi_ff, multi_in;
   logic       found_ff, found_in;

   logic byte_zero;
   logic push;
   logic enter;
   logic hit;
   logic tail_hit;
   logic flush;

   assign byte_zero = (text_byte == 8'h00);

   always_comb begin
      push     = 1'b0;
      enter    = 1'b0;
      phase_in = phase_ff;
      cont_in  = cont_ff;
      multi_in = multi_ff;
      if (phase_ff == PHASE_WIDE) begin
         push = 1'b1;
      end else if (cont_ff != 2'd0) begin
         if (text_byte[7:6] == CONT_TAG) begin
            cont_in = cont_ff - 2'd1;
            if (cont_ff == 2'd1) begin
               multi_in = 1'b1;
            end
         end else begin
            enter = 1'b1;
         end
      end else if (byte_zero) begin
         enter = 1'b1;
      end else if (text_byte < BYTE_HIGH) begin
         cont_in = 2'd0;
      end else if (text_byte < LEAD_TWO || text_byte >= LEAD_BAD) begin
         enter = 1'b1;
      end else if (text_byte >= LEAD_FOUR) begin
         cont_in = 2'd3;
      end else if (text_byte >= LEAD_THREE) begin
         cont_in = 2'd2;
      end else begin
         cont_in = 2'd1;
      end
      if (enter) begin
         phase_in = PHASE_WIDE;
         cont_in  = 2'd0;
      end
   end

   // NUL now, nonzero before it, NUL an odd distance further back
   assign hit      = push & byte_zero & head.valid & ~head.zero & odd_any;
   assign found_in = found_ff | hit;
   // end of buffer counts as NUL after a nonzero last byte
   assign tail_hit = push & ~byte_zero & even_any;

   always_comb begin
      if (phase_in == PHASE_UTF8) begin
         detect = (cont_in == 2'd0 && multi_in) ? ENC_UTF8 : ENC_ANSI;
      end else begin
         detect = (found_in | tail_hit) ? ENC_UTF16LE : ENC_ANSI;
      end
   end

   assign flush     = accept & final_byte;
   assign head_tap  = '{valid: 1'b1, zero: byte_zero};
   assign head_ctrl = '{shift: accept & (push | enter), clear: flush};
   assign body_ctrl = '{shift: accept & (push | enter), clear: flush | (accept & enter)};

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         phase_ff <= PHASE_UTF8;
         cont_ff  <= 2'd0;
         multi_ff <= 1'b0;
         found_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cont_ff  <= cont_in;
         multi_ff <= multi_in;
         found_ff <= found_in;
      end
   end

   a_cont_only_utf8: assert property (@(posedge clock) disable iff (reset)
      (cont_ff != 2'd0) |-> (phase_ff == PHASE_UTF8))
      else $error("continuation owed outside UTF-8 phase");

   a_found_only_wide: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (phase_ff == PHASE_WIDE))
      else $error("wide match flagged during UTF-8 phase");

endmodule

`default_nettype wire

/* rtl/text_encoding_detector.sv */
`default_nettype none

// Text encoding detector.
// req_chan carries one byte of a text buffer per transfer, with final_byte
// marking the last byte. rsp_chan carries one encoding code per buffer
// (0 ANSI, 1 UTF-8, 2 UTF-16LE), issued for the final byte only.
// csr_write_data sets the declared encoding when csr_write_enable is high;
// 3 means detect, anything else is passed through as the result. Write it
// between buffers.
// Throughput: one byte per cycle while no result waits on a stalled receiver.
// The result is loaded into the output register by the final byte's transfer.
// The result register is the only buffer on the response side; req_chan is
// ready whenever it is empty or being drained in the same cycle, so a
// stalled receiver holds off input only once a result is waiting.
// Reset clears the scan state and the window, empties the result register
// and sets the declared encoding to detect. After every final byte the scan
// state returns to its reset values; the declared encoding is kept.
// The NUL look-ahead is a chain of cells shifted one place per byte in the
// wide-character phase; the odd and even NUL taps are ORed in parallel.

module text_encoding_detector
   import ted_pkg::*;
#(
   parameter int LOOKAHEAD_SPAN = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   ted_req_if.sink          req_chan,
   ted_rsp_if.source        rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_write_data
);

   // cells needed to cover odd offsets up to the span; always even
   localparam int CELLS = 2 * ((LOOKAHEAD_SPAN + 1) / 2);

   logic       declared_fixed;
   logic [1:0] declared_enc_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_encoding_ff;

   logic          accept;
   tap_type       taps [CELLS];
   tap_type       head_tap;
   cell_ctrl_type head_ctrl;
   cell_ctrl_type body_ctrl;
   logic          odd_any;
   logic          even_any;
   logic [1:0]    detect;

   // declared encoding register
   always_ff @(posedge clock) begin
      if (reset) begin
         declared_enc_ff <= ENC_DETECT;
      end else if (csr_write_enable) begin
         declared_enc_ff <= csr_write_data;
      end
   end
   assign declared_fixed = (declared_enc_ff != ENC_DETECT);

   // input taken whenever the result slot is free or draining
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   // window chain: cell 0 holds the newest byte
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         ted_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (head_ctrl),
            .din   (head_tap),
            .dout  (taps[i])
         );
      end else begin : g_body
         ted_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (body_ctrl),
            .din   (taps[i-1]),
            .dout  (taps[i])
         );
      end
   end

   // NUL taps at odd and even places of the window
   always_comb begin
      odd_any  = 1'b0;
      even_any = 1'b0;
      for (int i = 0; i < CELLS; i++) begin
         if (i[0]) begin
            odd_any = odd_any | (taps[i].valid & taps[i].zero);
         end else begin
            even_any = even_any | (taps[i].valid & taps[i].zero);
         end
      end
   end

   ted_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_chan.text_byte),
      .final_byte (req_chan.final_byte),
      .head       (taps[0]),
      .odd_any    (odd_any),
      .even_any   (even_any),
      .head_ctrl  (head_ctrl),
      .body_ctrl  (body_ctrl),
      .head_tap   (head_tap),
      .detect     (detect)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_chan.final_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.final_byte) begin
         rsp_encoding_ff <= declared_fixed ? declared_enc_ff : detect;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.encoding = rsp_encoding_ff;

   a_declared_passes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.final_byte && declared_fixed)
         |=> (rsp_chan.valid && rsp_chan.encoding == $past(declared_enc_ff)))
      else $error("declared encoding not passed through");

   a_no_detect_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.encoding != ENC_DETECT))
      else $error("result carries the detect code");

   a_window_flushed: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.final_byte) |=> !taps[0].valid)
      else $error("window not cleared after final byte");

endmodule

`default_nettype wire

/* tb/tb_text_encoding_detector.sv */
`default_nettype none

module tb_text_encoding_detector;
   import ted_pkg::*;

   localparam int SPAN        = 16;          // NUL look-ahead span of the block
   localparam int DEPTH       = SPAN + 2;    // entries of the NUL history
   localparam int STUCK_LIMIT = 2000;        // cycles with no transfer before giving up
   localparam int SETTLE      = 4;           // result register latency plus margin

   typedef struct packed {
      logic       last;
      logic [7:0] text;
   } byte_item_type;

   typedef enum int {MIX_UTF8, MIX_WIDE, MIX_GAPS, MIX_NOISE} text_style_type;

   // Directed buffers, {last, byte} per entry:
   //   lone NUL; two-byte sequence; three- and four-byte sequences;
   //   "H\0i\0" wide text; NUL then a nonzero byte at the end (the byte past
   //   the end counts as zero); stray continuation; lead F8 and above;
   //   lead cut off by the end; plain ASCII; lead followed by a bad byte.
   localparam logic [0:25][8:0] DIRECTED = {
      9'h100,
      9'h0C3, 9'h1A9,
      9'h0E2, 9'h082, 9'h0AC, 9'h0F0, 9'h09F, 9'h098, 9'h180,
      9'h048, 9'h000, 9'h069, 9'h100,
      9'h041, 9'h000, 9'h142,
      9'h180,
      9'h1FF,
      9'h1C3,
      9'h17E,
      9'h0C3, 9'h041, 9'h000, 9'h07F, 9'h100
   };

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_write_data   = ENC_DETECT;

   ted_req_if req_bus ();
   ted_rsp_if rsp_bus ();

   text_encoding_detector #(
      .LOOKAHEAD_SPAN   (SPAN)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Bookkeeping
   // ---------------------------------------------------------------------
   byte_item_type text_queue [$];  // bytes waiting to be offered
   logic [1:0] encoding_due [$];   // predicted codes, oldest first

   logic req_taken = 1'b0;         // req transfer at the last rising edge
   logic no_stall  = 1'b0;         // both sides keep going flat out
   int   stuck_cycles  = 0;
   int   mismatches    = 0;
   int   bytes_queued  = 0;
   int   bytes_taken   = 0;
   int   results_seen  = 0;
   int   settings_used = 1;        // reset value counts as the first
   int   codes_seen [4] = '{0, 0, 0, 0};

   // ---------------------------------------------------------------------
   // Predictor state: only whether a byte was NUL matters once the wide
   // search has begun, so the history is a bit per byte, newest in bit 0.
   // ---------------------------------------------------------------------
   logic [1:0]     declared_enc;
   logic           wide_phase;     // 0 while UTF-8 validation holds
   logic [1:0]     cont_owed;      // continuation bytes still due
   logic           multibyte_ok;   // a complete multibyte sequence was seen
   logic           wide_hit;       // sticky UTF-16LE match
   logic [DEPTH:0] nul_map;
   int             map_fill;

   function automatic void clear_scan_state();
      wide_phase   = 1'b0;
      cont_owed    = 2'd0;
      multibyte_ok = 1'b0;
      wide_hit     = 1'b0;
      nul_map      = '0;
      map_fill     = 0;
   endfunction

   // Newest byte NUL, the one before nonzero, and a NUL an odd distance
   // further back within the span.
   function automatic logic odd_pair(input logic [DEPTH:0] map, input int fill);
      logic hit;
      int   k;
      hit = 1'b0;
      if (fill >= 3 && map[0] && !map[1]) begin
         for (k = 2; k <= SPAN + 1 && k < DEPTH; k += 2) begin
            if (k < fill && map[k])
               hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // Advance the scan by one byte; returns 1 with the code on a final byte.
   function automatic logic detect_step(input logic [7:0] b, input logic last,
                                        output logic [1:0] enc);
      logic go_wide;
      go_wide = 1'b0;
      enc     = ENC_ANSI;
      if (!wide_phase) begin
         if (cont_owed != 2'd0) begin
            if (b[7:6] == CONT_TAG) begin
               cont_owed = cont_owed - 2'd1;
               if (cont_owed == 2'd0)
                  multibyte_ok = 1'b1;
            end else begin
               // bad continuation: the wide search effectively starts here
               go_wide = 1'b1;
            end
         end else if (b == 8'h00 || (b >= BYTE_HIGH && b < LEAD_TWO) || b >= LEAD_BAD) begin
            go_wide = 1'b1;
         end else if (b >= LEAD_FOUR) begin
            cont_owed = 2'd3;
         end else if (b >= LEAD_THREE) begin
            cont_owed = 2'd2;
         end else if (b >= LEAD_TWO) begin
            cont_owed = 2'd1;
         end
      end
      if (go_wide) begin
         wide_phase = 1'b1;
         cont_owed  = 2'd0;
         map_fill   = 0;
         nul_map    = '0;
      end
      if (wide_phase) begin
         nul_map = {nul_map[DEPTH-1:0], b == 8'h00};
         if (map_fill < DEPTH)
            map_fill++;
         if (odd_pair(nul_map, map_fill))
            wide_hit = 1'b1;
      end
      if (!last)
         return 1'b0;
      if (!wide_phase)
         enc = (cont_owed == 2'd0 && multibyte_ok) ? ENC_UTF8 : ENC_ANSI;
      else if (wide_hit || odd_pair({nul_map[DEPTH-1:0], 1'b1}, map_fill + 1))
         enc = ENC_UTF16LE;   // a virtual NUL stands just past the end
      else
         enc = ENC_ANSI;
      if (declared_enc != ENC_DETECT)
         enc = declared_enc;
      clear_scan_state();
      return 1'b1;
   endfunction

   task automatic log_mismatch(input string what, input logic [1:0] want,
                               input logic [1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on result %0d: %s, expected %0d, got %0d",
                  results_seen, what, want, got);
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers the next byte at the falling edge once the previous
   // one has been taken; holds valid and payload steady while stalled.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      byte_item_type nxt;
      logic          send;
      if (!reset && (!req_bus.valid || req_taken)) begin
         send = text_queue.size() != 0 && (no_stall || $urandom_range(99) >= 28);
         if (send) begin
            nxt = text_queue.pop_front();
            req_bus.text_byte  <= nxt.text;
            req_bus.final_byte <= nxt.last;
         end
         req_bus.valid <= send;
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      if (!reset)
         rsp_bus.ready <= no_stall || $urandom_range(99) >= 28;
   end

   // ---------------------------------------------------------------------
   // Monitor: at the rising edge, feed accepted bytes to the predictor and
   // check each result transfer against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [1:0] want;
      logic       req_fire;
      logic       rsp_fire;
      req_fire = req_bus.valid && req_bus.ready;
      rsp_fire = rsp_bus.valid && rsp_bus.ready;
      if (reset) begin
         declared_enc = ENC_DETECT;
         clear_scan_state();
         req_taken    <= 1'b0;
         stuck_cycles <= 0;
      end else begin
         req_taken <= req_fire;
         if (csr_write_enable)
            declared_enc = csr_write_data;
         if (req_fire) begin
            bytes_taken++;
            if (detect_step(req_bus.text_byte, req_bus.final_byte, want))
               encoding_due.push_back(want);
         end
         if (rsp_fire) begin
            results_seen++;
            codes_seen[rsp_bus.encoding]++;
            if (encoding_due.size() == 0) begin
               log_mismatch("result with nothing outstanding", 2'bxx, rsp_bus.encoding);
            end else begin
               want = encoding_due.pop_front();
               if (rsp_bus.encoding !== want)
                  log_mismatch("encoding", want, rsp_bus.encoding);
            end
         end
         stuck_cycles <= (req_fire || rsp_fire) ? 0 : stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic add_buffer(input text_style_type style);
      logic [7:0]    chars [$];
      byte_item_type item;
      int            len;
      int            run;
      int            lead_len;
      // mostly short buffers, now and then a long one
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 20);
      while (chars.size() < len) begin
         case (style)
            MIX_UTF8: begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4: chars.push_back(8'($urandom_range(1, 127)));
                  5, 6, 7: begin
                     lead_len = $urandom_range(1, 3);
                     case (lead_len)
                        1:       chars.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                        2:       chars.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                        default: chars.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                     endcase
                     repeat (lead_len) chars.push_back({CONT_TAG, 6'($urandom)});
                  end
                  8: begin
                     // broken sequence: lead then a non-continuation byte
                     chars.push_back(8'($urandom_range(8'hC0, 8'hF7)));
                     chars.push_back(8'($urandom_range(0, 8'h7F)));
                  end
                  default: chars.push_back(8'($urandom_range(255)));
               endcase
            end
            MIX_WIDE: begin
               chars.push_back(8'(($urandom_range(3) == 0) ? $urandom_range(1, 255)
                                                            : $urandom_range(32, 126)));
               chars.push_back(8'(($urandom_range(7) == 0) ? $urandom_range(255) : 0));
            end
            MIX_GAPS: begin
               // NUL followed by a run that straddles the look-ahead span
               chars.push_back(8'h00);
               run = $urandom_range(0, SPAN + 3);
               repeat (run) chars.push_back(8'($urandom_range(1, 255)));
            end
            default: begin
               chars.push_back(8'(($urandom_range(3) == 0) ? 0 : $urandom_range(255)));
            end
         endcase
      end
      for (int i = 0; i < chars.size(); i++) begin
         item.text = chars[i];
         item.last = (i == chars.size() - 1);
         text_queue.push_back(item);
      end
      bytes_queued += chars.size();
   endtask

   // Register writes happen only with the block drained.
   task automatic write_setting(input logic [1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic settle();
      while (text_queue.size() != 0 || req_bus.valid || encoding_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      logic [1:0] fixed_codes [3];
      fixed_codes = '{ENC_ANSI, ENC_UTF16LE, ENC_UTF8};
      req_bus.valid      = 1'b0;
      req_bus.text_byte  = 8'h00;
      req_bus.final_byte = 1'b0;
      rsp_bus.ready      = 1'b0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed buffers with the reset setting (detect)
      for (int i = 0; i < $size(DIRECTED); i++)
         text_queue.push_back(byte_item_type'(DIRECTED[i]));
      bytes_queued += $size(DIRECTED);
      settle();

      // pass-through settings: the block must ignore the bytes' content
      foreach (fixed_codes[i]) begin
         write_setting(fixed_codes[i]);
         repeat (6) add_buffer(text_style_type'($urandom_range(3)));
         settle();
      end

      // detection, first without any stalls, then with them
      write_setting(ENC_DETECT);
      no_stall = 1'b1;
      while (bytes_queued < 650)
         add_buffer(text_style_type'($urandom_range(3)));
      settle();
      no_stall = 1'b0;
      while (bytes_queued < 1200)
         add_buffer(text_style_type'($urandom_range(3)));
      settle();

      $display("Run covered %0d bytes in %0d buffers over %0d register settings.",
               bytes_taken, results_seen, settings_used);
      $display("Codes returned: %0d ANSI, %0d UTF-8, %0d UTF-16LE; %0d mismatches.",
               codes_seen[ENC_ANSI], codes_seen[ENC_UTF8], codes_seen[ENC_UTF16LE],
               mismatches);
      if (mismatches == 0 && encoding_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog: too long without any transfer on either channel.
   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, encoding_due.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

/* text_encoding_detector.f */
rtl/ted_pkg.sv
rtl/ted_req_if.sv
rtl/ted_rsp_if.sv
rtl/ted_cell.sv
rtl/ted_scan.sv
rtl/text_encoding_detector.sv
tb/tb_text_encoding_detector.sv
